[sv/gisc_pkg.sv]
// shared constants and types for the greedy independent set completion block
package gisc_pkg;

	localparam int MAX_VERTICES = 32;
	localparam int VID_W        = $clog2(MAX_VERTICES);
	localparam int CNT_W        = 6;
	localparam int GRP_SIZE     = 8;
	localparam int NUM_GRP      = (MAX_VERTICES + GRP_SIZE - 1) / GRP_SIZE;

	localparam logic [CNT_W-1:0] VCOUNT_RST = CNT_W'(MAX_VERTICES);

	typedef logic [MAX_VERTICES-1:0] vset_t;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_EVAL = 1'b1
	} op_t;

	// packet that walks the cell chain
	typedef struct packed {
		logic  vld;
		vset_t avail;
		vset_t set;
	} pkt_t;

	// evaluate item after masking and clamping
	typedef struct packed {
		logic  vld;
		vset_t seed;
		vset_t pmask;
		vset_t nmask;
	} eval_t;

endpackage

[sv/gisc_cell.sv]
// one vertex cell: holds its adjacency row and makes the greedy decision for its vertex
module gisc_cell
	import gisc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [VID_W-1:0] cell_idx,
	input  logic             adv,
	input  logic             ld_en,
	input  logic [VID_W-1:0] ld_idx,
	input  vset_t            ld_row,
	input  pkt_t             pkt_in,
	output pkt_t             pkt_out,
	output vset_t            row
);

	vset_t row_q;
	logic  vld_q;
	vset_t avail_q;
	vset_t set_q;
	logic  take;

	// adjacency row storage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (ld_en && (ld_idx == cell_idx)) begin
			row_q <= ld_row;
		end
	end

	// vertex still free when the packet arrives: add it, drop its neighbors
	assign take = pkt_in.vld && pkt_in.avail[cell_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= pkt_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (take) begin
				avail_q <= pkt_in.avail & ~row_q;
				set_q   <= pkt_in.set | (vset_t'(1) << cell_idx);
			end else begin
				avail_q <= pkt_in.avail;
				set_q   <= pkt_in.set;
			end
		end
	end

	assign pkt_out = '{vld: vld_q, avail: avail_q, set: set_q};
	assign row     = row_q;

endmodule

[sv/gisc_nbr.sv]
// neighborhood of the seed and of its prefix, as a two level registered or tree
module gisc_nbr
	import gisc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  vset_t rows [MAX_VERTICES],
	input  eval_t ev,
	output pkt_t  pkt,
	output logic  pmax
);

	logic  vld_s2;
	vset_t seed_s2;
	vset_t pmask_s2;
	vset_t nmask_s2;
	vset_t part_all_s2 [NUM_GRP];
	vset_t part_p_s2   [NUM_GRP];
	vset_t part_all    [NUM_GRP];
	vset_t part_p      [NUM_GRP];
	vset_t seed_p;
	vset_t nbr_all;
	vset_t nbr_p;
	vset_t covered;

	assign seed_p = ev.seed & ev.pmask;

	// first level: or of gated rows within each group
	always_comb begin
		for (int g = 0; g < NUM_GRP; g++) begin
			part_all[g] = '0;
			part_p[g]   = '0;
			for (int k = 0; k < GRP_SIZE; k++) begin
				if (g * GRP_SIZE + k < MAX_VERTICES) begin
					if (ev.seed[g * GRP_SIZE + k]) begin
						part_all[g] = part_all[g] | rows[g * GRP_SIZE + k];
					end
					if (seed_p[g * GRP_SIZE + k]) begin
						part_p[g] = part_p[g] | rows[g * GRP_SIZE + k];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= ev.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ev.vld) begin
			seed_s2     <= ev.seed;
			pmask_s2    <= ev.pmask;
			nmask_s2    <= ev.nmask;
			part_all_s2 <= part_all;
			part_p_s2   <= part_p;
		end
	end

	// second level: combine the groups
	always_comb begin
		nbr_all = '0;
		nbr_p   = '0;
		for (int g = 0; g < NUM_GRP; g++) begin
			nbr_all = nbr_all | part_all_s2[g];
			nbr_p   = nbr_p | part_p_s2[g];
		end
	end

	// prefix domination test
	assign covered = ((seed_s2 & pmask_s2) | nbr_p) & pmask_s2;
	assign pmax    = (covered == pmask_s2);

	// free vertices seed the chain walk
	assign pkt = '{
		vld:   vld_s2,
		avail: nmask_s2 & ~(seed_s2 | nbr_all),
		set:   seed_s2
	};

endmodule

[sv/greedy_independent_set_completion_top.sv]
// top level: item intake, vertex count register, neighbor tree, cell chain, result register
// an evaluate transfer passes the two setup stages, then each cell of the 32 cell chain in order,
// then the result register; the chain stalls while a finished result cannot enter that register
// in_ready stays low from an evaluate transfer until its result is registered;
// a load gives no result
// reset: asynchronous, clears all adjacency rows to no edges and sets vertex_count to 32
module greedy_independent_set_completion_top
	import gisc_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_wr_en,
	input  logic [CNT_W-1:0]        cfg_wr_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    opcode,
	input  logic [VID_W-1:0]        vertex_index,
	input  logic [MAX_VERTICES-1:0] vertex_bits,
	input  logic [VID_W-1:0]        prefix_last,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [MAX_VERTICES-1:0] completed_set,
	output logic                    prefix_maximal
);

	logic [CNT_W-1:0] vcount_q;
	logic             busy_q;
	logic             pmax_q;
	logic             out_valid_q;
	vset_t            completed_set_q;
	logic             prefix_maximal_q;

	logic             in_xfer;
	logic             ld_en;
	logic             ev_en;
	logic [CNT_W-1:0] n;
	logic [CNT_W-1:0] jlim;
	vset_t            nmask;
	vset_t            pmask;
	eval_t            ev_s1;
	pkt_t             head_pkt;
	logic             pmax;
	pkt_t             chain [MAX_VERTICES+1];
	vset_t            rows  [MAX_VERTICES];
	logic             hold;
	logic             adv;
	logic             done;

	// vertex count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= VCOUNT_RST;
		end else if (cfg_wr_en) begin
			vcount_q <= cfg_wr_data;
		end
	end

	// input transfer decode
	assign in_ready = !busy_q;
	assign in_xfer  = in_valid && in_ready;
	assign ld_en    = in_xfer && (op_t'(opcode) == OP_LOAD);
	assign ev_en    = in_xfer && (op_t'(opcode) == OP_EVAL);

	// vertex mask and clamped prefix mask
	always_comb begin
		n     = (vcount_q > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : vcount_q;
		jlim  = ({1'b0, prefix_last} >= n) ? (n - CNT_W'(1)) : {1'b0, prefix_last};
		nmask = '0;
		pmask = '0;
		for (int k = 0; k < MAX_VERTICES; k++) begin
			nmask[k] = (CNT_W'(k) < n);
			pmask[k] = (n != '0) && (CNT_W'(k) <= jlim);
		end
	end

	// first setup stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_s1 <= '0;
		end else begin
			ev_s1.vld <= ev_en;
			if (ev_en) begin
				ev_s1.seed  <= vertex_bits & nmask;
				ev_s1.pmask <= pmask;
				ev_s1.nmask <= nmask;
			end
		end
	end

	gisc_nbr u_nbr (
		.clk    (clk),
		.arst_n (arst_n),
		.rows   (rows),
		.ev     (ev_s1),
		.pkt    (head_pkt),
		.pmax   (pmax)
	);

	// prefix result waits here while the packet walks the chain
	always_ff @(posedge clk) begin
		if (head_pkt.vld) begin
			pmax_q <= pmax;
		end
	end

	// chain stalls only when the finished packet cannot enter the result register
	assign hold = chain[MAX_VERTICES].vld && out_valid_q && !out_ready;
	assign adv  = !hold;
	assign done = chain[MAX_VERTICES].vld && adv;

	assign chain[0] = head_pkt;

	for (genvar g = 0; g < MAX_VERTICES; g++) begin : g_cell
		gisc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (VID_W'(g)),
			.adv      (adv),
			.ld_en    (ld_en),
			.ld_idx   (vertex_index),
			.ld_row   (vertex_bits),
			.pkt_in   (chain[g]),
			.pkt_out  (chain[g+1]),
			.row      (rows[g])
		);
	end

	// busy from evaluate transfer until its result is registered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (ev_en) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			completed_set_q  <= chain[MAX_VERTICES].set;
			prefix_maximal_q <= pmax_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign completed_set  = completed_set_q;
	assign prefix_maximal = prefix_maximal_q;

endmodule

[test/tb.sv]
// testbench for greedy_independent_set_completion_top: queued stimulus, in-order result checks
module tb;
	import gisc_pkg::*;

	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int NUM_PHASES   = 9;
	localparam int PHASE_ITEMS  = 205;

	typedef struct {
		op_t              op;
		logic [VID_W-1:0] vidx;
		vset_t            bits;
		logic [VID_W-1:0] plast;
	} item_t;

	typedef struct {
		vset_t members;
		logic  pmax;
	} completion_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_wr_en = 1'b0;
	logic [CNT_W-1:0]        cfg_wr_data = '0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic                    opcode = 1'b0;
	logic [VID_W-1:0]        vertex_index = '0;
	logic [MAX_VERTICES-1:0] vertex_bits = '0;
	logic [VID_W-1:0]        prefix_last = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b1;
	logic [MAX_VERTICES-1:0] completed_set;
	logic                    prefix_maximal;

	greedy_independent_set_completion_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.opcode         (opcode),
		.vertex_index   (vertex_index),
		.vertex_bits    (vertex_bits),
		.prefix_last    (prefix_last),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.completed_set  (completed_set),
		.prefix_maximal (prefix_maximal)
	);

	always #6 clk = ~clk;

	// predictor state: stored rows and vertex count as the block should hold them
	vset_t            adj_rows [MAX_VERTICES];
	logic [CNT_W-1:0] vertex_count_model = VCOUNT_RST;

	// graph that the stimulus generator is building, kept symmetric except for noise rows
	vset_t            shape_rows [MAX_VERTICES];

	item_t            pending_items [$];
	completion_t      expected_sets [$];
	int               items_outstanding = 0;
	int               phase_items = 0;
	int               mismatches = 0;
	int               cycle_count = 0;
	int               in_idle_pct = 0;
	int               out_stall_pct = 0;
	bit               in_took = 1'b0;

	initial begin
		for (int v = 0; v < MAX_VERTICES; v++) begin
			adj_rows[v] = '0;
			shape_rows[v] = '0;
		end
	end

	// union of the stored rows of every member
	function automatic vset_t rows_union(vset_t members);
		vset_t acc;
		acc = '0;
		for (int v = 0; v < MAX_VERTICES; v++)
			if (members[v])
				acc |= adj_rows[v];
		return acc;
	endfunction

	// prefix domination test and greedy ascending completion of the seed
	function automatic completion_t greedy_complete(vset_t seed_in, logic [VID_W-1:0] plast);
		completion_t res;
		int          n;
		int          j;
		vset_t       nmask;
		vset_t       pmask;
		vset_t       seed;
		vset_t       seed_p;
		vset_t       covered;
		vset_t       avail;
		n = (int'(vertex_count_model) > MAX_VERTICES) ? MAX_VERTICES : int'(vertex_count_model);
		nmask = vset_t'((64'd1 << n) - 64'd1);
		seed = seed_in & nmask;
		if (n == 0) begin
			pmask = '0;
		end else begin
			j = (int'(plast) > n - 1) ? n - 1 : int'(plast);
			pmask = vset_t'((64'd1 << (j + 1)) - 64'd1);
		end
		seed_p = seed & pmask;
		covered = (seed_p | rows_union(seed_p)) & pmask;
		res.members = seed;
		avail = nmask & ~(seed | rows_union(seed));
		for (int i = 0; i < MAX_VERTICES; i++) begin
			if (avail[i]) begin
				res.members[i] = 1'b1;
				avail &= ~adj_rows[i];
			end
		end
		res.members &= nmask;
		res.pmax = (covered == pmask);
		return res;
	endfunction

	// input side: accepted transfers update the rows or queue a prediction
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			in_took = 1'b1;
			items_outstanding--;
			if (opcode == OP_LOAD)
				adj_rows[vertex_index] = vertex_bits;
			else
				expected_sets.push_back(greedy_complete(vertex_bits, prefix_last));
		end
	end

	// result side: compare each transfer with the oldest prediction
	always @(posedge clk) begin : check_results
		completion_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_sets.size() == 0) begin
				$display("%0t unexpected result: completed_set %h prefix_maximal %b",
					$time, completed_set, prefix_maximal);
				mismatches++;
			end else begin
				want = expected_sets.pop_front();
				if (completed_set !== want.members) begin
					$display("%0t completed_set mismatch: expected %h actual %h",
						$time, want.members, completed_set);
					mismatches++;
				end
				if (prefix_maximal !== want.pmax) begin
					$display("%0t prefix_maximal mismatch: expected %b actual %b",
						$time, want.pmax, prefix_maximal);
					mismatches++;
				end
			end
		end
	end

	// driver: present the next queued item once the previous one has been taken
	always @(negedge clk) begin : drive_items
		item_t nxt;
		if (arst_n && (!in_valid || in_took)) begin
			in_took = 1'b0;
			if (pending_items.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
				nxt = pending_items.pop_front();
				in_valid     <= 1'b1;
				opcode       <= nxt.op;
				vertex_index <= nxt.vidx;
				vertex_bits  <= nxt.bits;
				prefix_last  <= nxt.plast;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver back-pressure
	always @(negedge clk) begin
		if (arst_n)
			out_ready <= ($urandom_range(99) >= out_stall_pct);
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	task automatic push_item(op_t op, int idx, vset_t bits, int plast);
		item_t it;
		it.op = op;
		it.vidx = VID_W'(idx);
		it.bits = bits;
		it.plast = VID_W'(plast);
		pending_items.push_back(it);
		items_outstanding++;
		phase_items++;
	endtask

	// fresh symmetric graph, every row rewritten
	task automatic load_graph(int density);
		for (int v = 0; v < MAX_VERTICES; v++)
			shape_rows[v] = '0;
		for (int v = 0; v < MAX_VERTICES; v++)
			for (int u = v + 1; u < MAX_VERTICES; u++)
				if ($urandom_range(99) < density) begin
					shape_rows[v][u] = 1'b1;
					shape_rows[u][v] = 1'b1;
				end
		for (int v = 0; v < MAX_VERTICES; v++)
			push_item(OP_LOAD, v, shape_rows[v], $urandom_range(31));
	endtask

	// flip one edge and reload both ends; u == v gives a self loop
	task automatic toggle_edge();
		int u;
		int v;
		u = $urandom_range(MAX_VERTICES - 1);
		v = $urandom_range(MAX_VERTICES - 1);
		shape_rows[u][v] = ~shape_rows[u][v];
		if (u != v)
			shape_rows[v][u] = ~shape_rows[v][u];
		push_item(OP_LOAD, u, shape_rows[u], $urandom_range(31));
		if (u != v)
			push_item(OP_LOAD, v, shape_rows[v], $urandom_range(31));
	endtask

	// one-sided row write, leaves the graph asymmetric
	task automatic noise_row();
		int    v;
		vset_t bits;
		v = $urandom_range(MAX_VERTICES - 1);
		bits = $urandom();
		shape_rows[v] = bits;
		push_item(OP_LOAD, v, bits, $urandom_range(31));
	endtask

	task automatic random_eval();
		int    kind;
		vset_t seed;
		kind = $urandom_range(9);
		case (kind)
			0, 1, 2, 3: begin
				seed = $urandom();
			end
			4, 5, 6: begin
				seed = '0;
				repeat ($urandom_range(1, 3))
					seed[$urandom_range(MAX_VERTICES - 1)] = 1'b1;
			end
			7: begin
				seed = '0;
			end
			8: begin
				seed = '1;
			end
			default: begin
				seed = '0;
				seed[$urandom_range(MAX_VERTICES - 1)] = 1'b1;
			end
		endcase
		push_item(OP_EVAL, $urandom_range(31), seed, $urandom_range(31));
	endtask

	// edge cases on a small hand-built graph
	task automatic directed_items();
		push_item(OP_EVAL, 0, 32'h0000_0000, 31);
		push_item(OP_EVAL, 31, 32'hFFFF_FFFF, 0);
		push_item(OP_LOAD, 0, 32'h0000_0002, 0);
		push_item(OP_LOAD, 1, 32'h0000_0005, 31);
		push_item(OP_LOAD, 2, 32'h0000_0002, 0);
		push_item(OP_EVAL, 0, 32'h0000_0002, 2);
		push_item(OP_EVAL, 0, 32'h0000_0001, 2);
		// seed that is not independent
		push_item(OP_EVAL, 0, 32'h0000_0003, 31);
		// asymmetric row with a self loop
		push_item(OP_LOAD, 31, 32'hFFFF_FFFF, 31);
		push_item(OP_EVAL, 0, 32'h8000_0000, 31);
		push_item(OP_EVAL, 0, 32'h0000_0000, 31);
		push_item(OP_EVAL, 0, 32'hAAAA_AAAA, 15);
		push_item(OP_LOAD, 5, 32'h5555_5555, 31);
		push_item(OP_EVAL, 0, 32'h0000_0020, 5);
		push_item(OP_EVAL, 0, 32'h5555_5555, 30);
		push_item(OP_LOAD, 31, 32'h0000_0000, 0);
	endtask

	// wait until every item is taken and every result has come, then let the pipe settle
	task automatic drain();
		while (items_outstanding != 0 || expected_sets.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_vertex_count(int value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= CNT_W'(value);
		vertex_count_model = CNT_W'(value);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// phase plan: vertex count per phase, idling cycles through four modes
	initial begin
		int counts [NUM_PHASES];
		int r;
		counts = '{32, 1, 32, 0, 63, 17, 5, 32, 24};
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p > 0)
				write_vertex_count(counts[p]);
			case (p % 4)
				0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
				1: begin in_idle_pct = 55; out_stall_pct = 0;  end
				2: begin in_idle_pct = 0;  out_stall_pct = 55; end
				default: begin in_idle_pct = 34; out_stall_pct = 34; end
			endcase
			phase_items = 0;
			if (p == 0)
				directed_items();
			case ($urandom_range(4))
				0: load_graph(0);
				1: load_graph(5);
				2: load_graph(15);
				3: load_graph(40);
				default: load_graph(90);
			endcase
			while (phase_items < PHASE_ITEMS) begin
				r = $urandom_range(99);
				if (r < 55)
					random_eval();
				else if (r < 85)
					toggle_edge();
				else if (r < 97)
					noise_row();
				else
					load_graph($urandom_range(60));
			end
			drain();
		end
		if (mismatches == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
